### design/semaphore_table_with_waiters_defines.svh
// Assertion macros shared by the semaphore table modules.
`ifndef SEMAPHORE_TABLE_WITH_WAITERS_DEFINES_SVH
`define SEMAPHORE_TABLE_WITH_WAITERS_DEFINES_SVH

// Antecedent holds: consequent holds in the same cycle.
`define SEMT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// Antecedent holds: consequent holds in the next cycle.
`define SEMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

### design/semt_pkg.sv
package semt_pkg;

   localparam logic [2:0] MODE_OPEN   = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_CLOSE  = 3'd2;
   localparam logic [2:0] MODE_WAIT   = 3'd3;
   localparam logic [2:0] MODE_POST   = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_EXISTS  = 3'd3;
   localparam logic [2:0] ST_QFULL   = 3'd4;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] sem_name;
      logic [15:0] initial_count;
      logic [15:0] caller_pid;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        caller_blocked;
      logic        wake_valid;
      logic [15:0] wake_pid;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;     // capture request, start lookup
      logic execute;  // apply update, issue queue access
      logic respond;  // drive response beat
   } cmd_type;

endpackage

### design/semaphore_table_with_waiters.sv
// The accepting edge registers the request; the beat is then taken in S_RESP after S_EXEC.
// No new request until back in idle; the controller runs lookup, update, respond in turn.
// The slot match runs over all slots in the lookup cycle; the queue memory is read in update.
// Reset clears all slots, counts, queue pointers and the live count at once; no sweep.
// Waiter storage is not cleared; only entries already queued are read back.
// The receiver cannot stall: each response is on the ports for exactly one cycle.
module semaphore_table_with_waiters #(
   parameter int SEM_SLOTS  = 16,
   parameter int WAIT_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  semt_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output semt_pkg::rsp_type  rsp_data
);

   semt_pkg::cmd_type cmd;

   semt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   semt_datapath #(
      .SEM_SLOTS  (SEM_SLOTS),
      .WAIT_DEPTH (WAIT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### design/semt_ctrl.sv
`include "semaphore_table_with_waiters_defines.svh"

module semt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output semt_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.load    = (state_ff == S_IDLE) && start;
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.respond = (state_ff == S_RESP);

   `SEMT_ASSERT_NEXT(a_load_exec, clock, reset, cmd.load, cmd.execute)
   `SEMT_ASSERT_NEXT(a_exec_resp, clock, reset, cmd.execute, cmd.respond)
   `SEMT_ASSERT_IMP(a_cmd_onehot, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.execute, cmd.respond}))

endmodule

### design/semt_datapath.sv
`include "semaphore_table_with_waiters_defines.svh"

module semt_datapath #(
   parameter int SEM_SLOTS  = 16,
   parameter int WAIT_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  semt_pkg::cmd_type  cmd,
   input  semt_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output semt_pkg::rsp_type  rsp_data
);

   localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FW = $clog2(WAIT_DEPTH + 1);
   localparam int LW = $clog2(SEM_SLOTS + 1);
   localparam int MW = SW + QW;
   localparam int MD = 1 << MW;

   logic [31:0]   name_ff  [SEM_SLOTS];
   logic [15:0]   count_ff [SEM_SLOTS];
   logic [QW-1:0] head_ff  [SEM_SLOTS];
   logic [FW-1:0] fill_ff  [SEM_SLOTS];
   logic [LW-1:0] live_ff;

   logic [15:0]   waiter_mem [MD];
   logic [15:0]   rd_data_ff;

   semt_pkg::req_type req_ff;
   logic          hit_ff;
   logic [SW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [SW-1:0] free_idx_ff;

   logic [2:0]    status_ff;
   logic          blocked_ff;
   logic          wake_ff;

   logic          hit_in;
   logic [SW-1:0] hit_idx_in;
   logic          free_in;
   logic [SW-1:0] free_idx_in;

   // Match the id and find the first empty slot at load.
   always_comb begin
      hit_in      = 1'b0;
      hit_idx_in  = '0;
      free_in     = 1'b0;
      free_idx_in = '0;
      for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
         if (name_ff[i] == req_data.sem_name) begin
            hit_in     = 1'b1;
            hit_idx_in = SW'(i);
         end
         if (name_ff[i] == 32'd0) begin
            free_in     = 1'b1;
            free_idx_in = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         free_ff     <= free_in;
         free_idx_ff <= free_idx_in;
      end
   end

   logic          valid_id;
   logic [15:0]   cur_count;
   logic [QW-1:0] cur_head;
   logic [FW-1:0] cur_fill;
   logic [QW:0]   tail_sum;
   logic [QW-1:0] tail_pos;
   logic [QW-1:0] head_next;
   logic          do_alloc;
   logic          do_close;
   logic          do_dec;
   logic          do_enq;
   logic          do_deq;
   logic          do_inc;
   logic [2:0]    status_in;

   assign valid_id  = (req_ff.sem_name != 32'd0);
   assign cur_count = count_ff[hit_idx_ff];
   assign cur_head  = head_ff[hit_idx_ff];
   assign cur_fill  = fill_ff[hit_idx_ff];
   assign tail_sum  = {1'b0, cur_head} + (QW+1)'(cur_fill);
   assign tail_pos  = (tail_sum >= (QW+1)'(WAIT_DEPTH))
                      ? QW'(tail_sum - (QW+1)'(WAIT_DEPTH)) : tail_sum[QW-1:0];
   assign head_next = ((QW+1)'(cur_head) + 1'b1 >= (QW+1)'(WAIT_DEPTH))
                      ? '0 : QW'(cur_head + 1'b1);

   always_comb begin
      do_alloc  = 1'b0;
      do_close  = 1'b0;
      do_dec    = 1'b0;
      do_enq    = 1'b0;
      do_deq    = 1'b0;
      do_inc    = 1'b0;
      status_in = semt_pkg::ST_OK;
      if (!valid_id) begin
         status_in = semt_pkg::ST_INVALID;
      end else begin
         case (req_ff.mode)
            semt_pkg::MODE_OPEN, semt_pkg::MODE_CREATE: begin
               if (hit_ff) begin
                  status_in = (req_ff.mode == semt_pkg::MODE_OPEN)
                              ? semt_pkg::ST_OK : semt_pkg::ST_EXISTS;
               end else if (!free_ff || live_ff >= LW'(SEM_SLOTS)) begin
                  status_in = semt_pkg::ST_FULL;
               end else begin
                  do_alloc = 1'b1;
               end
            end
            semt_pkg::MODE_CLOSE: begin
               if (!hit_ff) status_in = semt_pkg::ST_INVALID;
               else do_close = 1'b1;
            end
            semt_pkg::MODE_WAIT: begin
               if (!hit_ff) status_in = semt_pkg::ST_INVALID;
               else if (cur_count != 16'd0) do_dec = 1'b1;
               else if (cur_fill >= FW'(WAIT_DEPTH)) status_in = semt_pkg::ST_QFULL;
               else do_enq = 1'b1;
            end
            semt_pkg::MODE_POST: begin
               if (!hit_ff) status_in = semt_pkg::ST_INVALID;
               else if (cur_fill != '0) do_deq = 1'b1;
               else if (cur_count != semt_pkg::COUNT_MAX) do_inc = 1'b1;
            end
            default: status_in = semt_pkg::ST_INVALID;
         endcase
      end
   end

   logic [MW-1:0] enq_addr;
   logic [MW-1:0] deq_addr;
   assign enq_addr = {hit_idx_ff, tail_pos};
   assign deq_addr = {hit_idx_ff, cur_head};

   // Queue memory: one write or one registered read per item.
   always_ff @(posedge clock) begin
      if (cmd.execute && do_enq) waiter_mem[enq_addr] <= req_ff.caller_pid;
      rd_data_ff <= waiter_mem[deq_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEM_SLOTS; i++) begin
            name_ff[i]  <= '0;
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
         live_ff <= '0;
      end else if (cmd.execute) begin
         if (do_alloc) begin
            name_ff[free_idx_ff]  <= req_ff.sem_name;
            count_ff[free_idx_ff] <= req_ff.initial_count;
            head_ff[free_idx_ff]  <= '0;
            fill_ff[free_idx_ff]  <= '0;
            live_ff <= live_ff + 1'b1;
         end
         if (do_close) begin
            name_ff[hit_idx_ff]  <= '0;
            count_ff[hit_idx_ff] <= '0;
            head_ff[hit_idx_ff]  <= '0;
            fill_ff[hit_idx_ff]  <= '0;
            if (live_ff != '0) live_ff <= live_ff - 1'b1;
         end
         if (do_dec) count_ff[hit_idx_ff] <= cur_count - 16'd1;
         if (do_inc) count_ff[hit_idx_ff] <= cur_count + 16'd1;
         if (do_enq) fill_ff[hit_idx_ff] <= cur_fill + 1'b1;
         if (do_deq) begin
            fill_ff[hit_idx_ff] <= cur_fill - 1'b1;
            head_ff[hit_idx_ff] <= head_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         blocked_ff <= do_enq;
         wake_ff    <= do_deq;
      end
   end

   assign rsp_strobe              = cmd.respond;
   assign rsp_data.status         = status_ff;
   assign rsp_data.caller_blocked = blocked_ff;
   assign rsp_data.wake_valid     = wake_ff;
   assign rsp_data.wake_pid       = wake_ff ? rd_data_ff : 16'd0;

   `SEMT_ASSERT_IMP(a_live_bound, clock, reset, 1'b1, live_ff <= LW'(SEM_SLOTS))
   `SEMT_ASSERT_IMP(a_one_update, clock, reset, cmd.execute,
      $onehot0({do_alloc, do_close, do_dec, do_enq, do_deq, do_inc}))
   `SEMT_ASSERT_IMP(a_wake_ok, clock, reset, rsp_strobe && rsp_data.wake_valid,
      rsp_data.status == semt_pkg::ST_OK && !rsp_data.caller_blocked)

endmodule
